[sv/pss_pkg.sv]
// Shared types, codes and constants for the PLL setting search block.
package pss_pkg;

  localparam int unsigned HZ_W   = 32;
  localparam int unsigned SRC_W  = 3;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned WAIT_W = 3;
  // The product of a 32-bit frequency and a multiplier of at most 16 needs 36 bits.
  localparam int unsigned PROD_W = HZ_W + 4;
  localparam int unsigned PADDR_W = 5;

  localparam logic [SRC_W-1:0] SRC_HSI        = 3'd0;
  localparam logic [SRC_W-1:0] SRC_HSE        = 3'd1;
  localparam logic [SRC_W-1:0] SRC_LSE        = 3'd2;
  localparam logic [SRC_W-1:0] SRC_LSI        = 3'd3;
  localparam logic [SRC_W-1:0] SRC_HSI_DIRECT = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADSRC = 2'd2;

  localparam logic [CODE_W-1:0] MULT_LAST  = 4'd15;
  localparam logic [CODE_W-1:0] SHIFT_LAST = 4'd8;
  localparam logic [CODE_W-1:0] DIV_FIRST  = 4'd7;

  localparam logic [2:0] REG_HSI   = 3'd0;
  localparam logic [2:0] REG_HSE   = 3'd1;
  localparam logic [2:0] REG_LSE   = 3'd2;
  localparam logic [2:0] REG_LSI   = 3'd3;
  localparam logic [2:0] REG_CAP   = 3'd4;
  localparam logic [2:0] REG_LIMIT = 3'd5;

  localparam logic [HZ_W-1:0] HSI_RESET   = 32'd8_000_000;
  localparam logic [HZ_W-1:0] HSE_RESET   = 32'd8_000_000;
  localparam logic [HZ_W-1:0] LSE_RESET   = 32'd32_768;
  localparam logic [HZ_W-1:0] LSI_RESET   = 32'd40_000;
  localparam logic [HZ_W-1:0] CAP_RESET   = 32'd80_000_000;
  localparam logic [HZ_W-1:0] LIMIT_RESET = 32'd80_000_000;

  localparam logic [HZ_W-1:0] WAIT_STEP_HZ = 32'd25_000_000;
  localparam int unsigned     WAIT_MAX     = 7;

  // Flash wait states: one per full 25 MHz step, saturating at seven.
  // Each step is a compare against a constant threshold.
  function automatic logic [WAIT_W-1:0] wait_for(input logic [HZ_W-1:0] hz);
    logic [WAIT_W-1:0] w;
    w = '0;
    for (int k = 1; k <= WAIT_MAX; k++) begin
      if (hz >= HZ_W'(k * WAIT_STEP_HZ)) begin
        w = WAIT_W'(k);
      end
    end
    return w;
  endfunction

  typedef struct packed {
    logic            start;
    logic [HZ_W-1:0] base;
    logic [HZ_W-1:0] req;
    logic [HZ_W-1:0] limit;
  } search_cmd_t;

  typedef struct packed {
    logic              done;
    logic [HZ_W-1:0]   solved;
    logic [CODE_W-1:0] mult;
    logic [CODE_W-1:0] divc;
  } search_res_t;

endpackage

[sv/pss_ifs.sv]
// Valid/ready channel interfaces for the request and result words.
interface pss_req_if;
  import pss_pkg::*;
  logic              valid;
  logic              ready;
  logic [HZ_W-1:0]   requested_hz;
  logic [SRC_W-1:0]  clock_source;
  modport source(output valid, requested_hz, clock_source, input ready);
  modport sink(input valid, requested_hz, clock_source, output ready);
endinterface

interface pss_res_if;
  import pss_pkg::*;
  logic              valid;
  logic              ready;
  logic [HZ_W-1:0]   solved_hz;
  logic [CODE_W-1:0] mult_code;
  logic [CODE_W-1:0] div_code;
  logic [STAT_W-1:0] status;
  logic [WAIT_W-1:0] wait_states;
  modport source(output valid, solved_hz, mult_code, div_code, status, wait_states,
                 input ready);
  modport sink(input valid, solved_hz, mult_code, div_code, status, wait_states,
               output ready);
endinterface

[sv/pss_search.sv]
// Candidate search engine: one multiplier/divider candidate evaluated per cycle.
module pss_search (
  input  logic                 clk,
  input  logic                 rst,
  input  pss_pkg::search_cmd_t cmd,
  output pss_pkg::search_res_t res
);
  import pss_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t              state;
  logic                done;
  logic [HZ_W-1:0]     base;
  logic [HZ_W-1:0]     req;
  logic [HZ_W-1:0]     best;
  logic [HZ_W-1:0]     solved;
  logic [CODE_W-1:0]   mult;
  logic [CODE_W-1:0]   shift;
  logic [CODE_W-1:0]   best_mult;
  logic [CODE_W-1:0]   best_shift;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   cand;

  logic [PROD_W-1:0]   prod_next;
  logic [HZ_W-1:0]     c;
  logic [HZ_W:0]       up_diff;
  logic [HZ_W-1:0]     dn_diff;
  logic [HZ_W-1:0]     df;
  logic                in_range;
  logic                better;
  logic                exact;
  logic                last;

  always_comb begin
    prod_next = prod + {{(PROD_W-HZ_W){1'b0}}, base};
    in_range  = cand <= {{(PROD_W-HZ_W){1'b0}}, cmd.limit};
    c         = cand[HZ_W-1:0];
    up_diff   = {1'b0, c} - {1'b0, req};
    dn_diff   = req - c;
    df        = up_diff[HZ_W] ? dn_diff : up_diff[HZ_W-1:0];
    better    = in_range && (df < best);
    exact     = in_range && (df == '0);
    last      = (mult == MULT_LAST) && (shift == SHIFT_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state      <= S_RUN;
            base       <= cmd.base;
            req        <= cmd.req;
            best       <= cmd.req;
            solved     <= '0;
            best_mult  <= '0;
            best_shift <= '0;
            mult       <= '0;
            shift      <= '0;
            prod       <= {{(PROD_W-HZ_W){1'b0}}, cmd.base};
            cand       <= {{(PROD_W-HZ_W){1'b0}}, cmd.base};
          end
        end
        S_RUN: begin
          if (better) begin
            best       <= df;
            solved     <= c;
            best_mult  <= mult;
            best_shift <= shift;
          end
          // Once the distance reaches zero nothing later can be strictly closer.
          if (exact || last) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else if (shift == SHIFT_LAST) begin
            mult  <= mult + 4'd1;
            shift <= '0;
            prod  <= prod_next;
            cand  <= prod_next;
          end else begin
            shift <= shift + 4'd1;
            cand  <= cand >> 1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.done   = done;
  assign res.solved = solved;
  assign res.mult   = best_mult;
  assign res.divc   = best_shift + DIV_FIRST;

endmodule

[sv/pll_setting_search.sv]
// Top level of the PLL setting search: register file, sequencing and result word.
//
// A request word (requested_hz, clock_source) enters on the request channel and one
// result word leaves on the result channel for each request. The six frequency
// registers are written and read over the APB port; write them only while idle.
// For HSI and HSE the search engine tries one multiplier/divider candidate per
// cycle, multipliers 1 to 16 in the outer order and divider codes 7 to 15 in the
// inner order, and ends early on an exact match. When the search finishes, the
// sequencer enters the load state, which fills the output register when free;
// LSE, LSI, HSI direct and invalid sources take no search and enter it on accept.
// The search loop sets the rate: one request is in work at a time,
// and request.ready is high only while no request is in work.
// A finished word waits in the output register while the receiver stalls; the
// block can accept the next request meanwhile, but holds that request's result
// until the waiting word has been taken.
// Reset clears the control state and returns the six frequency registers to their reset values.
module pll_setting_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pss_pkg::PADDR_W-1:0]  paddr,
  input  logic [pss_pkg::HZ_W-1:0]     pwdata,
  output logic [pss_pkg::HZ_W-1:0]     prdata,
  output logic                         pready,
  pss_req_if.sink                      request,
  pss_res_if.source                    result
);
  import pss_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_LOAD} state_t;

  state_t            state;
  logic [SRC_W-1:0]  src;
  logic [HZ_W-1:0]   hsi_hz;
  logic [HZ_W-1:0]   hse_hz;
  logic [HZ_W-1:0]   lse_hz;
  logic [HZ_W-1:0]   lsi_hz;
  logic [HZ_W-1:0]   request_cap_hz;
  logic [HZ_W-1:0]   valid_limit_hz;

  logic              out_valid;
  logic [HZ_W-1:0]   out_solved;
  logic [CODE_W-1:0] out_mult;
  logic [CODE_W-1:0] out_div;
  logic [STAT_W-1:0] out_status;
  logic [WAIT_W-1:0] out_wait;

  logic              cfg_wr;
  logic              accept;
  logic              is_search;
  logic              out_free;
  logic [HZ_W-1:0]   req_clamped;
  logic [HZ_W-1:0]   fin_solved;
  logic [CODE_W-1:0] fin_mult;
  logic [CODE_W-1:0] fin_div;
  logic [STAT_W-1:0] fin_status;
  logic [WAIT_W-1:0] fin_wait;

  search_cmd_t       cmd;
  search_res_t       res;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign accept    = request.valid && request.ready;
  assign is_search = request.clock_source inside {SRC_HSI, SRC_HSE};
  assign out_free  = !out_valid || result.ready;

  assign request.ready = (state == S_IDLE);

  assign req_clamped = (request.requested_hz > request_cap_hz) ? request_cap_hz
                                                               : request.requested_hz;

  assign cmd.start = accept && is_search;
  assign cmd.base  = (request.clock_source == SRC_HSE) ? hse_hz : hsi_hz;
  assign cmd.req   = req_clamped;
  assign cmd.limit = valid_limit_hz;

  pss_search u_search (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_HSI:   prdata = hsi_hz;
      REG_HSE:   prdata = hse_hz;
      REG_LSE:   prdata = lse_hz;
      REG_LSI:   prdata = lsi_hz;
      REG_CAP:   prdata = request_cap_hz;
      REG_LIMIT: prdata = valid_limit_hz;
      default:   prdata = '0;
    endcase
  end

  // Assemble the final word from the latched source and either the search results or the frequency registers.
  always_comb begin
    fin_solved = '0;
    fin_mult   = '0;
    fin_div    = DIV_FIRST;
    fin_status = ST_OK;
    case (src)
      SRC_HSI, SRC_HSE: begin
        fin_solved = res.solved;
        fin_mult   = res.mult;
        fin_div    = res.divc;
        fin_status = (res.solved < valid_limit_hz) ? ST_OK : ST_FAIL;
      end
      SRC_LSE:        fin_solved = lse_hz;
      SRC_LSI:        fin_solved = lsi_hz;
      SRC_HSI_DIRECT: fin_solved = hsi_hz;
      default:        fin_status = ST_BADSRC;
    endcase
    fin_wait = (fin_status == ST_OK) ? wait_for(fin_solved) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsi_hz         <= HSI_RESET;
      hse_hz         <= HSE_RESET;
      lse_hz         <= LSE_RESET;
      lsi_hz         <= LSI_RESET;
      request_cap_hz <= CAP_RESET;
      valid_limit_hz <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_HSI:   hsi_hz         <= pwdata;
        REG_HSE:   hse_hz         <= pwdata;
        REG_LSE:   lse_hz         <= pwdata;
        REG_LSI:   lsi_hz         <= pwdata;
        REG_CAP:   request_cap_hz <= pwdata;
        REG_LIMIT: valid_limit_hz <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the load state the output register is refilled below whenever it is free.
      if (out_valid && result.ready && state != S_LOAD) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            src   <= request.clock_source;
            state <= is_search ? S_RUN : S_LOAD;
          end
        end
        S_RUN: begin
          if (res.done) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_solved <= fin_solved;
            out_mult   <= fin_mult;
            out_div    <= fin_div;
            out_status <= fin_status;
            out_wait   <= fin_wait;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.solved_hz   = out_solved;
  assign result.mult_code   = out_mult;
  assign result.div_code    = out_div;
  assign result.status      = out_status;
  assign result.wait_states = out_wait;

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    res.done |-> state == S_RUN)
    else $error("search finished while the sequencer was not waiting for it");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_RUN)
    else $error("search started without the sequencer entering the run state");

  a_wait_only_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK |-> result.wait_states == '0)
    else $error("wait states reported on a failed setting");

  a_badsrc_clear: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_BADSRC |->
      result.solved_hz == '0 && result.mult_code == '0 && result.div_code == DIV_FIRST)
    else $error("bad source word carries a setting");

endmodule
